@@ rtl/write_burst_hysteresis_switch_core_assert.svh @@
// assertion macros shared by the write burst hysteresis switch rtl
// each macro expects i_clk and i_rst_n in the scope of the module that uses it
`ifndef WRITE_BURST_HYSTERESIS_SWITCH_CORE_ASSERT_SVH
`define WRITE_BURST_HYSTERESIS_SWITCH_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define WBHS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wbhs assertion failed: same-cycle check");

// consequent checked in the cycle after the antecedent
`define WBHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wbhs assertion failed: next-cycle check");

`endif

@@ rtl/wbhs_pkg.sv @@
// ---------------------------------------------------------------------------
// wbhs_pkg
// types, codes and defaults of the write burst hysteresis switch
// ---------------------------------------------------------------------------
package wbhs_pkg;

    // default parameter values
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int RUN_BITS_DEF     = 8;

    // fixed field widths
    localparam int SECTORS_W = 32;
    localparam int MS_W      = 32;
    localparam int THR_W     = 48;
    localparam int PERIOD_W  = 8;
    localparam int ACTION_W  = 2;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 64;

    // bytes per second scale applied to milliseconds
    localparam int MS_PER_S = 1000;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FORCE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESET  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SPARE  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_THRESHOLD      = 2'd0;
    localparam logic [1:0] REG_ENABLE_PER     = 2'd1;
    localparam logic [1:0] REG_DISABLE_PER    = 2'd2;
    localparam logic [1:0] REG_FORCED_DIS_PER = 2'd3;

    // register reset values
    localparam logic [THR_W-1:0]    THRESHOLD_RST      = 48'd52428800;
    localparam logic [PERIOD_W-1:0] ENABLE_PER_RST     = 8'd3;
    localparam logic [PERIOD_W-1:0] DISABLE_PER_RST    = 8'd5;
    localparam logic [PERIOD_W-1:0] FORCED_DIS_PER_RST = 8'd60;

endpackage

@@ rtl/write_burst_hysteresis_switch_core.sv @@
// ---------------------------------------------------------------------------
// write_burst_hysteresis_switch_core: bandwidth hysteresis write boost switch
// an update runs a multiply and a bit-serial divide (S_MUL, S_DIV) before S_FIN
// a new transaction is taken only in S_IDLE, once the last result is registered
// sync active-low reset: registers to defaults, state cleared, boost off
// ---------------------------------------------------------------------------
`include "write_burst_hysteresis_switch_core_assert.svh"

module write_burst_hysteresis_switch_core #(
    parameter int SECTOR_BYTES = wbhs_pkg::SECTOR_BYTES_DEF,
    parameter int RUN_BITS     = wbhs_pkg::RUN_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [63:0]                 i_s_tdata,  // written_sectors[31:0], elapsed_ms[63:32]
    input  logic [1:0]                  i_s_tuser,  // action[1:0]
    // result stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [7:0]                  o_m_tdata,  // boost_on[0], toggle_issued[1],
                                                    // bad_interval[2], zero pad[7:3]
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wbhs_pkg::APB_AW-1:0] paddr,
    input  logic [wbhs_pkg::APB_DW-1:0] pwdata,
    output logic [wbhs_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    // derived widths
    localparam int SCALE   = SECTOR_BYTES * wbhs_pkg::MS_PER_S;
    localparam int SCALE_W = $clog2(SCALE + 1);
    localparam int PROD_W  = wbhs_pkg::SECTORS_W + SCALE_W;
    localparam int CNT_W   = $clog2(PROD_W);
    localparam int CMP_W   = (PROD_W > wbhs_pkg::THR_W) ? PROD_W : wbhs_pkg::THR_W;
    localparam int RW      = (RUN_BITS > wbhs_pkg::PERIOD_W) ? RUN_BITS : wbhs_pkg::PERIOD_W;
    localparam int MS_W    = wbhs_pkg::MS_W;
    localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} t_state;

    t_state                         r_state;
    logic [CNT_W-1:0]               r_cnt;
    logic [wbhs_pkg::ACTION_W-1:0]  r_action;
    logic                           r_zero;
    logic [wbhs_pkg::SECTORS_W-1:0] r_sectors;
    logic [MS_W-1:0]                r_ms;
    logic [PROD_W-1:0]              r_dvd;
    logic [MS_W-1:0]                r_rem;

    logic [RUN_BITS-1:0]            r_high_run;
    logic [RUN_BITS-1:0]            r_low_run;
    logic                           r_forced;
    logic                           r_decision;

    logic                           r_out_valid;
    logic [2:0]                     r_out_data;

    logic [wbhs_pkg::THR_W-1:0]     r_thr;
    logic [wbhs_pkg::PERIOD_W-1:0]  r_en_per;
    logic [wbhs_pkg::PERIOD_W-1:0]  r_dis_per;
    logic [wbhs_pkg::PERIOD_W-1:0]  r_fdis_per;

    // handshakes
    logic s_xact;
    logic upd_start;
    logic out_free;
    logic fin_fire;
    logic cfg_wr;
    logic [1:0] cfg_idx;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_xact     = i_s_tvalid && o_s_tready;
    assign upd_start  = s_xact && (i_s_tuser == wbhs_pkg::ACT_UPDATE)
                        && (i_s_tdata[63:32] != '0);
    assign out_free   = !r_out_valid || i_m_tready;
    assign fin_fire   = (r_state == S_FIN) && out_free;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_data};
    assign pready     = 1'b1;
    assign cfg_idx    = paddr[4:3];
    assign cfg_wr     = psel && penable && pwrite && pready;

    // divider step: shift in next dividend bit, subtract divisor when it fits
    logic [MS_W:0] trial;
    logic          fits;
    logic [MS_W:0] trial_diff;

    assign trial      = {r_rem, r_dvd[PROD_W-1]};
    assign fits       = trial >= {1'b0, r_ms};
    assign trial_diff = trial - {1'b0, r_ms};

    // decision logic evaluated in the final state
    logic                bw_ge;
    logic [RUN_BITS-1:0] hi_inc;
    logic [RUN_BITS-1:0] lo_inc;
    logic [RUN_BITS-1:0] n_high;
    logic [RUN_BITS-1:0] n_low;
    logic                n_forced;
    logic                n_decision;
    logic                n_toggle;
    logic                n_bad;
    logic                target;

    assign bw_ge  = CMP_W'(r_dvd) >= CMP_W'(r_thr);
    assign hi_inc = (r_high_run == RUN_MAX) ? RUN_MAX : r_high_run + 1'b1;
    assign lo_inc = (r_low_run == RUN_MAX) ? RUN_MAX : r_low_run + 1'b1;

    always_comb begin
        n_high     = r_high_run;
        n_low      = r_low_run;
        n_forced   = r_forced;
        n_decision = r_decision;
        n_toggle   = 1'b0;
        n_bad      = 1'b0;
        target     = r_decision;
        priority if (r_action == wbhs_pkg::ACT_UPDATE) begin
            if (r_zero) begin
                n_bad = 1'b1;
            end else begin
                n_high = bw_ge ? hi_inc : '0;
                n_low  = bw_ge ? '0 : lo_inc;
                if (RW'(n_high) >= RW'(r_en_per)) begin
                    target = 1'b1;
                end
                if (!r_forced && (RW'(n_low) >= RW'(r_dis_per))) begin
                    target = 1'b0;
                end
                if (r_forced && (RW'(n_low) >= RW'(r_fdis_per))) begin
                    target = 1'b0;
                end
                if (target != r_decision) begin
                    n_toggle   = 1'b1;
                    n_forced   = r_forced && target;
                    n_decision = target;
                end
            end
        end else if (r_action == wbhs_pkg::ACT_FORCE) begin
            n_high     = '0;
            n_low      = '0;
            n_forced   = 1'b1;
            n_decision = 1'b1;
            n_toggle   = 1'b1;
        end else if (r_action == wbhs_pkg::ACT_RESET) begin
            n_high     = '0;
            n_low      = '0;
            n_forced   = 1'b0;
            n_decision = 1'b0;
            n_toggle   = 1'b1;
        end
    end

    // sequencer, shared divider datapath and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_high_run  <= '0;
            r_low_run   <= '0;
            r_forced    <= 1'b0;
            r_decision  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && !fin_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_xact) begin
                        r_action  <= i_s_tuser;
                        r_sectors <= i_s_tdata[31:0];
                        r_ms      <= i_s_tdata[63:32];
                        r_zero    <= (i_s_tdata[63:32] == '0);
                        if (upd_start) begin
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_MUL: begin
                    r_dvd   <= PROD_W'(r_sectors) * PROD_W'(SCALE);
                    r_rem   <= '0;
                    r_cnt   <= CNT_W'(PROD_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= fits ? trial_diff[MS_W-1:0] : trial[MS_W-1:0];
                    r_dvd <= {r_dvd[PROD_W-2:0], fits};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_high_run  <= n_high;
                        r_low_run   <= n_low;
                        r_forced    <= n_forced;
                        r_decision  <= n_decision;
                        r_out_data  <= {n_bad, n_toggle, n_decision};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= wbhs_pkg::THRESHOLD_RST;
            r_en_per   <= wbhs_pkg::ENABLE_PER_RST;
            r_dis_per  <= wbhs_pkg::DISABLE_PER_RST;
            r_fdis_per <= wbhs_pkg::FORCED_DIS_PER_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                wbhs_pkg::REG_THRESHOLD:      r_thr      <= pwdata[wbhs_pkg::THR_W-1:0];
                wbhs_pkg::REG_ENABLE_PER:     r_en_per   <= pwdata[wbhs_pkg::PERIOD_W-1:0];
                wbhs_pkg::REG_DISABLE_PER:    r_dis_per  <= pwdata[wbhs_pkg::PERIOD_W-1:0];
                wbhs_pkg::REG_FORCED_DIS_PER: r_fdis_per <= pwdata[wbhs_pkg::PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (cfg_idx)
            wbhs_pkg::REG_THRESHOLD:      prdata = wbhs_pkg::APB_DW'(r_thr);
            wbhs_pkg::REG_ENABLE_PER:     prdata = wbhs_pkg::APB_DW'(r_en_per);
            wbhs_pkg::REG_DISABLE_PER:    prdata = wbhs_pkg::APB_DW'(r_dis_per);
            wbhs_pkg::REG_FORCED_DIS_PER: prdata = wbhs_pkg::APB_DW'(r_fdis_per);
            default:                      prdata = '0;
        endcase
    end

    // checks on the sequencer and the decision state
    `WBHS_ASSERT_NOW(a_forced_implies_on, r_forced, r_decision)
    `WBHS_ASSERT_NOW(a_out_matches_decision, r_out_valid, r_out_data[0] == r_decision)
    `WBHS_ASSERT_NOW(a_bad_never_toggles, r_out_valid, !(r_out_data[1] && r_out_data[2]))
    `WBHS_ASSERT_NEXT(a_update_starts_mul, upd_start, r_state == S_MUL)
    `WBHS_ASSERT_NOW(a_result_from_fin, $rose(r_out_valid), $past(r_state == S_FIN))

endmodule

@@ bench/wbhs_switch_checker.sv @@
// ---------------------------------------------------------------------------
// wbhs_switch_checker: result checker for the write burst hysteresis switch
// watches the input stream, the result stream and configuration writes,
// predicts each boost decision from its own copy of the registers and state,
// and compares every result transaction field by field in order
// ---------------------------------------------------------------------------
module wbhs_switch_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [63:0]                 i_s_tdata,   // written_sectors[31:0], elapsed_ms[63:32]
    input  logic [1:0]                  i_s_tuser,   // action[1:0]
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [7:0]                  i_m_tdata,   // boost_on[0], toggle_issued[1],
                                                     // bad_interval[2], zero pad[7:3]
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wbhs_pkg::APB_AW-1:0] paddr,
    input  logic [wbhs_pkg::APB_DW-1:0] pwdata,
    input  logic                        pready,
    output int                          o_fail_count,
    output int                          o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                  RUN_BITS     = wbhs_pkg::RUN_BITS_DEF;
    localparam logic [RUN_BITS-1:0] RUN_MAX      = '1;
    localparam logic [63:0]         BYTES_PER_MS = wbhs_pkg::SECTOR_BYTES_DEF
                                                   * wbhs_pkg::MS_PER_S;

    typedef struct packed {
        logic [4:0] pad;
        logic       bad_interval;
        logic       toggle_issued;
        logic       boost_on;
    } t_switch_result;

    // register copies
    logic [wbhs_pkg::THR_W-1:0]    thr_reg;
    logic [wbhs_pkg::PERIOD_W-1:0] enable_per_reg;
    logic [wbhs_pkg::PERIOD_W-1:0] disable_per_reg;
    logic [wbhs_pkg::PERIOD_W-1:0] forced_dis_per_reg;

    // switch state copies
    logic [RUN_BITS-1:0] high_count;
    logic [RUN_BITS-1:0] low_count;
    logic                forced_state;
    logic                boost_state;

    t_switch_result expected_decisions[$];
    int             fail_count = 0;

    assign o_fail_count = fail_count;

    // next boost decision for one input transaction, updates the state copies
    function automatic t_switch_result predict_boost_decision(
        input logic [1:0]  action,
        input logic [31:0] sectors,
        input logic [31:0] ms
    );
        logic [63:0]    bandwidth;
        logic           target;
        t_switch_result res;
        res = '0;
        unique case (action)
            wbhs_pkg::ACT_UPDATE: begin
                if (ms == '0) begin
                    res.bad_interval = 1'b1;
                end else begin
                    bandwidth = ({32'd0, sectors} * BYTES_PER_MS) / {32'd0, ms};
                    target = boost_state;
                    if (bandwidth >= {16'd0, thr_reg}) begin
                        high_count = (high_count == RUN_MAX) ? RUN_MAX : high_count + 1'b1;
                        low_count  = '0;
                    end else begin
                        high_count = '0;
                        low_count  = (low_count == RUN_MAX) ? RUN_MAX : low_count + 1'b1;
                    end
                    if (high_count >= enable_per_reg)
                        target = 1'b1;
                    if (!forced_state && low_count >= disable_per_reg)
                        target = 1'b0;
                    if (forced_state && low_count >= forced_dis_per_reg)
                        target = 1'b0;
                    if (target != boost_state) begin
                        res.toggle_issued = 1'b1;
                        forced_state = forced_state && target;
                        boost_state  = target;
                    end
                end
            end
            wbhs_pkg::ACT_FORCE: begin
                forced_state = 1'b1;
                high_count   = '0;
                low_count    = '0;
                boost_state  = 1'b1;
                res.toggle_issued = 1'b1;
            end
            wbhs_pkg::ACT_RESET: begin
                forced_state = 1'b0;
                high_count   = '0;
                low_count    = '0;
                boost_state  = 1'b0;
                res.toggle_issued = 1'b1;
            end
            default: ;
        endcase
        res.boost_on = boost_state;
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic [7:0] exp_val,
                                 input logic [7:0] act_val);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: result mismatch on %s: expected %0h, got %0h",
                     $realtime, field, exp_val, act_val);
    endtask

    // compare results, predict accepted items, track register writes
    always @(posedge i_clk) begin
        t_switch_result got;
        t_switch_result want;
        if (!i_rst_n) begin
            thr_reg            = wbhs_pkg::THRESHOLD_RST;
            enable_per_reg     = wbhs_pkg::ENABLE_PER_RST;
            disable_per_reg    = wbhs_pkg::DISABLE_PER_RST;
            forced_dis_per_reg = wbhs_pkg::FORCED_DIS_PER_RST;
            high_count         = '0;
            low_count          = '0;
            forced_state       = 1'b0;
            boost_state        = 1'b0;
            expected_decisions.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_switch_result'(i_m_tdata);
                if (expected_decisions.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result transaction %0h with nothing expected",
                                 $realtime, i_m_tdata);
                end else begin
                    want = expected_decisions.pop_front();
                    if (got.boost_on !== want.boost_on)
                        note_mismatch("boost_on", 8'(want.boost_on), 8'(got.boost_on));
                    if (got.toggle_issued !== want.toggle_issued)
                        note_mismatch("toggle_issued", 8'(want.toggle_issued),
                                      8'(got.toggle_issued));
                    if (got.bad_interval !== want.bad_interval)
                        note_mismatch("bad_interval", 8'(want.bad_interval),
                                      8'(got.bad_interval));
                    if (got.pad !== want.pad)
                        note_mismatch("pad", 8'(want.pad), 8'(got.pad));
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_decisions.push_back(predict_boost_decision(
                    i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32]));
            if (psel && penable && pwrite && pready) begin
                unique case (paddr[4:3])
                    wbhs_pkg::REG_THRESHOLD:
                        thr_reg = pwdata[wbhs_pkg::THR_W-1:0];
                    wbhs_pkg::REG_ENABLE_PER:
                        enable_per_reg = pwdata[wbhs_pkg::PERIOD_W-1:0];
                    wbhs_pkg::REG_DISABLE_PER:
                        disable_per_reg = pwdata[wbhs_pkg::PERIOD_W-1:0];
                    wbhs_pkg::REG_FORCED_DIS_PER:
                        forced_dis_per_reg = pwdata[wbhs_pkg::PERIOD_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending_count = expected_decisions.size();
    end

endmodule

@@ bench/tb_write_burst_hysteresis_switch_core.sv @@
// ---------------------------------------------------------------------------
// tb_write_burst_hysteresis_switch_core: write burst switch testbench
// drives update, forced enable and reset transactions through the stream
// input in random bursts under several register settings, stalls the result
// stream, and takes the verdict from the checker beside the block
// ---------------------------------------------------------------------------
module tb_write_burst_hysteresis_switch_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [63:0]                   i_s_tdata  = '0;
    logic [1:0]                    i_s_tuser  = wbhs_pkg::ACT_UPDATE;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [7:0]                    o_m_tdata;
    logic                          psel       = 1'b0;
    logic                          penable    = 1'b0;
    logic                          pwrite     = 1'b0;
    logic [wbhs_pkg::APB_AW-1:0]   paddr      = '0;
    logic [wbhs_pkg::APB_DW-1:0]   pwdata     = '0;
    logic [wbhs_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    int                            fail_count;
    int                            pending_count;
    int                            burst_left = 0;
    int                            stall_left = 0;
    int                            stall_mode = 0;
    logic [wbhs_pkg::THR_W-1:0]    cur_thr    = wbhs_pkg::THRESHOLD_RST;

    always #6 i_clk = ~i_clk;

    write_burst_hysteresis_switch_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    wbhs_switch_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_s_tuser       (i_s_tuser),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // result side backpressure in one of four patterns, picked anew at random
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 400);
        end else begin
            stall_left--;
        end
        unique case (stall_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= ($urandom_range(0, 1) == 1);
            2:       i_m_tready <= ($urandom_range(0, 7) == 0);
            default: i_m_tready <= (stall_left % 5 != 0);
        endcase
    end

    // one stream transaction, then a random gap when the burst runs out
    task automatic send_item(input logic [1:0] action, input logic [31:0] sectors,
                             input logic [31:0] ms);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= action;
        i_s_tdata  <= {ms, sectors};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // drop valid and hold off until every result has come back
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx,
                             input logic [wbhs_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [wbhs_pkg::THR_W-1:0] thr,
                                  input logic [7:0] en_per, input logic [7:0] dis_per,
                                  input logic [7:0] fdis_per);
        write_reg(wbhs_pkg::REG_THRESHOLD, {16'd0, thr});
        write_reg(wbhs_pkg::REG_ENABLE_PER, {56'd0, en_per});
        write_reg(wbhs_pkg::REG_DISABLE_PER, {56'd0, dis_per});
        write_reg(wbhs_pkg::REG_FORCED_DIS_PER, {56'd0, fdis_per});
        cur_thr = thr;
    endtask

    // sector count landing at or just over, or just under, the threshold for this interval
    function automatic logic [31:0] pick_sectors(input bit want_high, input logic [31:0] ms);
        logic [63:0] need;
        logic [63:0] sel;
        need = ({16'd0, cur_thr} * {32'd0, ms} + 64'd4095999) / 64'd4096000;
        if (want_high)
            sel = need + $urandom_range(0, 2);
        else if (need == 0)
            sel = 0;
        else
            sel = need - 1 - ((need > 1) ? $urandom_range(0, 1) : 0);
        return (sel > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sel[31:0];
    endfunction

    // mostly runs of intensive or quiet periods, with forced enables, resets and noise
    task automatic run_random(input int budget);
        int    count;
        int    kind;
        int    run_len;
        bit    dir;
        logic [31:0] ms;
        count = 0;
        while (count < budget) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                dir = $urandom_range(0, 1);
                if ($urandom_range(0, 19) == 0)
                    run_len = $urandom_range(200, 300);
                else if ($urandom_range(0, 3) == 0)
                    run_len = $urandom_range(13, 80);
                else
                    run_len = $urandom_range(1, 12);
                if (run_len > budget - count)
                    run_len = budget - count;
                repeat (run_len) begin
                    ms = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                      : $urandom_range(1, 1000);
                    send_item(wbhs_pkg::ACT_UPDATE, pick_sectors(dir, ms), ms);
                    count++;
                end
            end else if (kind < 70) begin
                send_item(wbhs_pkg::ACT_FORCE, $urandom, $urandom);
                count++;
            end else if (kind < 75) begin
                send_item(wbhs_pkg::ACT_RESET, $urandom, $urandom);
                count++;
            end else if (kind < 80) begin
                send_item(wbhs_pkg::ACT_UPDATE, $urandom, '0);
                count++;
            end else if (kind < 83) begin
                send_item(wbhs_pkg::ACT_SPARE, $urandom, $urandom);
                count++;
            end else if (kind < 99) begin
                send_item(wbhs_pkg::ACT_UPDATE, $urandom, $urandom);
                count++;
            end else begin
                wait_drained();
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at a short hysteresis
        apply_settings(wbhs_pkg::THRESHOLD_RST, 8'd2, 8'd2, 8'd3);
        send_item(wbhs_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 32'd0);          // zero interval
        send_item(wbhs_pkg::ACT_UPDATE, 32'd0, 32'd1);                  // quiet
        send_item(wbhs_pkg::ACT_UPDATE, 32'd0, 32'hFFFF_FFFF);          // quiet, already off
        send_item(wbhs_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // largest both, quiet
        send_item(wbhs_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 32'd1);          // largest bandwidth
        send_item(wbhs_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 32'd1);          // switches on
        send_item(wbhs_pkg::ACT_UPDATE, 32'd64, 32'd5);                 // exactly at threshold
        send_item(wbhs_pkg::ACT_UPDATE, 32'd63, 32'd5);                 // just under
        send_item(wbhs_pkg::ACT_UPDATE, 32'd12, 32'd1);                 // switches off
        send_item(wbhs_pkg::ACT_FORCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(wbhs_pkg::ACT_FORCE, 32'd0, 32'd0);                   // already on, again
        send_item(wbhs_pkg::ACT_UPDATE, 32'd0, 32'd9);
        send_item(wbhs_pkg::ACT_UPDATE, 32'd0, 32'd9);                  // held by forced count
        send_item(wbhs_pkg::ACT_UPDATE, 32'd0, 32'd9);                  // forced count reached
        send_item(wbhs_pkg::ACT_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // unused action
        send_item(wbhs_pkg::ACT_UPDATE, 32'd13, 32'd1);
        send_item(wbhs_pkg::ACT_UPDATE, 32'd13, 32'd1);                 // on again
        send_item(wbhs_pkg::ACT_UPDATE, 32'd13, 32'd0);                 // zero interval, on
        send_item(wbhs_pkg::ACT_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(wbhs_pkg::ACT_RESET, 32'd0, 32'd0);
        send_item(wbhs_pkg::ACT_UPDATE, 32'd13, 32'd1);

        // random phases under several settings, extremes included
        for (int phase = 0; phase < 6; phase++) begin
            wait_drained();
            repeat (4) @(negedge i_clk);
            unique case (phase)
                0: apply_settings(wbhs_pkg::THRESHOLD_RST, wbhs_pkg::ENABLE_PER_RST,
                                  wbhs_pkg::DISABLE_PER_RST, wbhs_pkg::FORCED_DIS_PER_RST);
                1: apply_settings('0, 8'd1, 8'd1, 8'd1);
                2: apply_settings('1, 8'd255, 8'd255, 8'd255);
                3: apply_settings({16'd0, $urandom}, 8'd0, 8'($urandom_range(1, 6)), 8'd0);
                4: apply_settings({8'd0, 8'($urandom_range(0, 255)), $urandom},
                                  8'($urandom_range(1, 6)), 8'd0,
                                  8'($urandom_range(1, 20)));
                default: apply_settings({16'($urandom_range(0, 65535)), $urandom},
                                        8'($urandom_range(1, 255)),
                                        8'($urandom_range(1, 255)),
                                        8'($urandom_range(1, 255)));
            endcase
            run_random(230);
        end

        wait_drained();
        repeat (80) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_write_burst_hysteresis_switch_core: PASS");
        else
            $display("tb_write_burst_hysteresis_switch_core: FAIL");
        $finish;
    end

    // run time limit
    initial begin
        #24_000_000;
        $display("tb_write_burst_hysteresis_switch_core: FAIL");
        $finish;
    end

endmodule
